>>> rtl/core/mbe_pkg.sv
package mbe_pkg;

  localparam int COORD_BITS = 24;

  // Magnitude of one coordinate or of one box edge (max - min)
  localparam int MAG_W    = COORD_BITS + 1;
  // Sum of three squares of MAG_W-bit magnitudes
  localparam int ACC_W    = 2 * MAG_W;
  // Largest squared vertex distance is at most 3 * 2^(2*COORD_BITS-2)
  localparam int PEAK_W   = 2 * COORD_BITS;
  localparam int ROOT_W   = ACC_W / 2;
  localparam int RADIUS_W = COORD_BITS + 1;
  localparam int DIAG_W   = COORD_BITS + 2;

  localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef struct packed {
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic signed [COORD_BITS-1:0] vertex_z;
    logic                         last_vertex;
  } vertex_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] box_min_x;
    logic signed [COORD_BITS-1:0] box_min_y;
    logic signed [COORD_BITS-1:0] box_min_z;
    logic signed [COORD_BITS-1:0] box_max_x;
    logic signed [COORD_BITS-1:0] box_max_y;
    logic signed [COORD_BITS-1:0] box_max_z;
    logic        [RADIUS_W-1:0]   far_radius;
    logic        [DIAG_W-1:0]     diagonal_length;
    logic signed [COORD_BITS-1:0] centre_x;
    logic signed [COORD_BITS-1:0] centre_y;
    logic signed [COORD_BITS-1:0] centre_z;
  } extents_t;

  typedef struct packed {
    logic             start;
    logic [ACC_W-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

endpackage

>>> rtl/core/mbe_isqrt.sv
module mbe_isqrt import mbe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  sqrt_req_t req,
  output sqrt_rsp_t rsp
);

  localparam int REM_W  = ROOT_W + 3;
  localparam int STEP_W = $clog2(ROOT_W + 1);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [ACC_W-1:0]    rad_r, rad_nxt;
  logic [REM_W-1:0]    rem_r, rem_nxt;
  logic [ROOT_W-1:0]   root_r, root_nxt;

  logic [REM_W-1:0]    rem_sh;
  logic [REM_W-1:0]    trial;
  logic                fits;

  // One result bit per cycle: bring down two radicand bits, try root*4+1
  assign rem_sh = {rem_r[REM_W-3:0], rad_r[ACC_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(ROOT_W);
      rad_nxt  = req.radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rad_nxt  = {rad_r[ACC_W-3:0], 2'b00};
      rem_nxt  = fits ? (rem_sh - trial) : rem_sh;
      root_nxt = {root_r[ROOT_W-2:0], fits};
      step_nxt = step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.root = root_r;

  a_no_start_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !req.start)
    else $error("root started while busy");

  a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ($past(busy_r) && !busy_r))
    else $error("root done without a run");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (step_r != '0))
    else $error("root step count ran out while busy");

endmodule

>>> rtl/core/mesh_bounding_extents.sv
// Streaming bounding box and bounding sphere of a mesh. Each input word is one
// vertex (signed Q12.12 x, y, z) with a last-vertex mark. The block keeps the
// running per-axis minimum and maximum and the largest squared distance from
// the origin; on the marked vertex it returns one result word with the box
// corners, the floor square root of that distance, the floor length of the box
// diagonal and the box centre (min + max halved, rounded towards minus
// infinity), and then reseeds for the next model. One multiplier squares the
// three magnitudes in turn, so an ordinary vertex occupies the block through
// accept, three squares plus one accumulate, and the peak compare. A last
// vertex adds the diagonal squares, two passes of the bit-serial root unit
// and the load of the result, plus any time for which an earlier result
// still holds the output register. in_stall is high for the whole of that
// time. The result sits in an output register, so the next vertex is taken
// while an earlier result still waits for the sink.
module mesh_bounding_extents import mbe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  vertex_t  in_word,
  output logic     out_valid,
  input  logic     out_stall,
  output extents_t out_word
);

  localparam int CB = COORD_BITS;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_PEAK   = 3'd2;
  localparam logic [2:0] ST_ROOT_R = 3'd3;
  localparam logic [2:0] ST_ROOT_D = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;

  localparam logic [1:0] LAST_STEP = 2'd3;

  logic [2:0]              state_r, state_nxt;
  logic [1:0]              cnt_r, cnt_nxt;
  logic                    diag_r, diag_nxt;
  logic                    last_r, last_nxt;
  logic [MAG_W-1:0]        vmag_r [3];
  logic [MAG_W-1:0]        vmag_nxt [3];
  logic signed [CB-1:0]    low_r [3];
  logic signed [CB-1:0]    low_nxt [3];
  logic signed [CB-1:0]    high_r [3];
  logic signed [CB-1:0]    high_nxt [3];
  logic [PEAK_W-1:0]       peak_r, peak_nxt;
  logic [ACC_W-1:0]        prod_r, prod_nxt;
  logic [ACC_W-1:0]        acc_r, acc_nxt;
  logic [ROOT_W-1:0]       radius_r, radius_nxt;
  logic                    out_valid_r, out_valid_nxt;
  extents_t                out_r, out_nxt;

  logic signed [CB-1:0]    in_coord [3];
  logic signed [MAG_W-1:0] in_ext [3];
  logic signed [MAG_W-1:0] edge_len;
  logic signed [MAG_W-1:0] mid_sum [3];
  logic [1:0]              ax;
  logic [MAG_W-1:0]        mul_a;
  logic                    load_ok;
  sqrt_req_t               sq_req;
  sqrt_rsp_t               sq_rsp;

  assign in_coord[0] = in_word.vertex_x;
  assign in_coord[1] = in_word.vertex_y;
  assign in_coord[2] = in_word.vertex_z;

  // Sign-extend by one bit so that the magnitude of the most negative value fits
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      in_ext[k]  = {in_coord[k][CB-1], in_coord[k]};
      mid_sum[k] = MAG_W'({low_r[k][CB-1], low_r[k]}) + MAG_W'({high_r[k][CB-1], high_r[k]});
    end
  end

  // Shared squarer: vertex magnitudes first, box edges on the diagonal pass
  assign ax       = (cnt_r == LAST_STEP) ? 2'd0 : cnt_r;
  assign edge_len = MAG_W'({high_r[ax][CB-1], high_r[ax]}) - MAG_W'({low_r[ax][CB-1], low_r[ax]});
  assign mul_a    = diag_r ? MAG_W'(edge_len) : vmag_r[ax];
  assign prod_nxt = ACC_W'(mul_a) * ACC_W'(mul_a);

  assign load_ok = !out_valid_r || !out_stall;

  // Root unit runs on the peak first, then on the squared diagonal
  always_comb begin
    sq_req.start    = 1'b0;
    sq_req.radicand = ACC_W'(peak_r);
    if (state_r == ST_MUL && diag_r && cnt_r == LAST_STEP) begin
      sq_req.start = 1'b1;
    end else if (state_r == ST_ROOT_R && sq_rsp.done) begin
      sq_req.start    = 1'b1;
      sq_req.radicand = acc_r;
    end
  end

  mbe_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sq_req),
    .rsp   (sq_rsp)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    diag_nxt      = diag_r;
    last_nxt      = last_r;
    vmag_nxt      = vmag_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    peak_nxt      = peak_r;
    acc_nxt       = acc_r;
    radius_nxt    = radius_r;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          // Fold the vertex into the box straight away; squares follow
          for (int k = 0; k < 3; k++) begin
            if (in_coord[k] < low_r[k])  low_nxt[k]  = in_coord[k];
            if (in_coord[k] > high_r[k]) high_nxt[k] = in_coord[k];
            vmag_nxt[k] = in_ext[k][MAG_W-1] ? MAG_W'(-in_ext[k]) : MAG_W'(in_ext[k]);
          end
          last_nxt  = in_word.last_vertex;
          cnt_nxt   = 2'd0;
          diag_nxt  = 1'b0;
          acc_nxt   = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        // Product of step n is added at step n+1
        if (cnt_r != 2'd0) acc_nxt = acc_r + prod_r;
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == LAST_STEP) state_nxt = diag_r ? ST_ROOT_R : ST_PEAK;
      end
      ST_PEAK: begin
        if (acc_r > ACC_W'(peak_r)) peak_nxt = PEAK_W'(acc_r);
        if (last_r) begin
          diag_nxt  = 1'b1;
          cnt_nxt   = 2'd0;
          acc_nxt   = '0;
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ROOT_R: begin
        if (sq_rsp.done) begin
          radius_nxt = sq_rsp.root;
          state_nxt  = ST_ROOT_D;
        end
      end
      ST_ROOT_D: begin
        if (sq_rsp.done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        // Hold until the output register is free, then reseed
        if (load_ok) begin
          out_valid_nxt = 1'b1;
          for (int k = 0; k < 3; k++) begin
            low_nxt[k]  = COORD_MAX;
            high_nxt[k] = COORD_MIN;
          end
          peak_nxt  = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result word; only loaded on the emit cycle
  always_comb begin
    out_nxt = out_r;
    if (state_r == ST_EMIT && load_ok) begin
      out_nxt.box_min_x       = low_r[0];
      out_nxt.box_min_y       = low_r[1];
      out_nxt.box_min_z       = low_r[2];
      out_nxt.box_max_x       = high_r[0];
      out_nxt.box_max_y       = high_r[1];
      out_nxt.box_max_z       = high_r[2];
      out_nxt.far_radius      = RADIUS_W'(radius_r);
      out_nxt.diagonal_length = DIAG_W'(sq_rsp.root);
      out_nxt.centre_x        = mid_sum[0][MAG_W-1:1];
      out_nxt.centre_y        = mid_sum[1][MAG_W-1:1];
      out_nxt.centre_z        = mid_sum[2][MAG_W-1:1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      peak_r      <= '0;
      for (int k = 0; k < 3; k++) begin
        low_r[k]  <= COORD_MAX;
        high_r[k] <= COORD_MIN;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      peak_r      <= peak_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
    end
    cnt_r    <= cnt_nxt;
    diag_r   <= diag_nxt;
    last_r   <= last_nxt;
    vmag_r   <= vmag_nxt;
    prod_r   <= prod_nxt;
    acc_r    <= acc_nxt;
    radius_r <= radius_nxt;
    out_r    <= out_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("result word raised outside the emit step");

  a_reseed_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && load_ok) |=> (peak_r == '0 && state_r == ST_IDLE))
    else $error("state not reseeded after a result");

  a_root_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    sq_rsp.done |-> (state_r == ST_ROOT_R || state_r == ST_ROOT_D))
    else $error("root finished while not awaited");

  a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> ($signed(low_r[0]) <= $signed(high_r[0])
                              && $signed(low_r[2]) <= $signed(high_r[2])))
    else $error("box minimum above maximum at emit");

endmodule

>>> test/mesh_bounding_extents_tb.sv
`timescale 1ns / 100ps

module mesh_bounding_extents_tb;
  import mbe_pkg::*;

  // Give up well beyond the slowest legal run: every vertex closing a model
  // (each one running the root unit twice) with the sink stalling most of the time.
  localparam int CYCLE_LIMIT   = 600000;
  localparam int PHASE_ITEMS   = 650;
  localparam int HOLD_CYCLES   = 500;
  localparam int DRAIN_CYCLES  = 80;
  localparam int N_DIRECTED    = 20;
  localparam int REPORT_LIMIT  = 10;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  vertex_t  in_word;
  logic     out_valid;
  logic     out_stall;
  extents_t out_word;

  mesh_bounding_extents u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // One row of the directed table: the vertex word, and where the result can
  // be read straight off the geometry, the extents it must produce.
  typedef struct packed {
    vertex_t  vtx;
    logic     typed;
    extents_t want;
  } stim_row_t;

  stim_row_t directed_rows [N_DIRECTED] = '{
    // lone vertex at the origin: everything zero
    '{'{'0, '0, '0, 1'b1}, 1'b1, '0},
    // lone vertex on each axis extreme: radius is the coordinate magnitude
    '{'{COORD_MAX, '0, '0, 1'b1}, 1'b1,
      '{COORD_MAX, '0, '0, COORD_MAX, '0, '0,
        RADIUS_W'(2**(COORD_BITS-1) - 1), '0, COORD_MAX, '0, '0}},
    '{'{'0, COORD_MIN, '0, 1'b1}, 1'b1,
      '{'0, COORD_MIN, '0, '0, COORD_MIN, '0,
        RADIUS_W'(2**(COORD_BITS-1)), '0, '0, COORD_MIN, '0}},
    '{'{'0, '0, COORD_MIN, 1'b1}, 1'b1,
      '{'0, '0, COORD_MIN, '0, '0, COORD_MIN,
        RADIUS_W'(2**(COORD_BITS-1)), '0, '0, '0, COORD_MIN}},
    // lone vertex one LSB below zero on all axes: floor root of 3 is 1
    '{'{'1, '1, '1, 1'b1}, 1'b1,
      '{'1, '1, '1, '1, '1, '1, RADIUS_W'(1), '0, '1, '1, '1}},
    // full-range box both ways round: widest diagonal, centre rounds down
    '{'{COORD_MIN, COORD_MIN, COORD_MIN, 1'b0}, 1'b0, '0},
    '{'{COORD_MAX, COORD_MAX, COORD_MAX, 1'b1}, 1'b0, '0},
    '{'{COORD_MAX, COORD_MAX, COORD_MAX, 1'b0}, 1'b0, '0},
    '{'{COORD_MIN, COORD_MIN, COORD_MIN, 1'b1}, 1'b0, '0},
    '{'{COORD_MAX, COORD_MIN, COORD_MAX, 1'b0}, 1'b0, '0},
    '{'{COORD_MIN, COORD_MAX, COORD_MIN, 1'b1}, 1'b0, '0},
    // largest squared distance from a single corner
    '{'{COORD_MIN, COORD_MIN, COORD_MIN, 1'b1}, 1'b0, '0},
    // alternating bit patterns
    '{'{24'sh555555, 24'shAAAAAA, 24'sh555555, 1'b0}, 1'b0, '0},
    '{'{24'shAAAAAA, 24'sh555555, 24'shAAAAAA, 1'b0}, 1'b0, '0},
    '{'{24'sd1, 24'sd2, 24'sd3, 1'b1}, 1'b0, '0},
    // odd min + max on the outer axes
    '{'{24'sd1, 24'sd2, 24'sd3, 1'b0}, 1'b0, '0},
    '{'{-24'sd2, -24'sd2, -24'sd2, 1'b1}, 1'b0, '0},
    // ordinary small model
    '{'{24'sd5, -24'sd7, 24'sd9, 1'b0}, 1'b0, '0},
    '{'{-24'sd3, 24'sd4, -24'sd100, 1'b0}, 1'b0, '0},
    '{'{24'sd1000, 24'sd2000, -24'sd3000, 1'b1}, 1'b0, '0}
  };

  // Running extents of the model being folded in
  longint          lo_edge [3];
  longint          hi_edge [3];
  longint unsigned peak_sq;

  extents_t pending_extents [$];
  int       mismatches;
  int       results_seen;
  int       vertices_taken;
  int       cycle_count;
  int       src_gap_pct;
  int       sink_stall_pct;
  int       hold_left;
  bit       hold_request;

  function automatic void reseed_extents();
    for (int a = 0; a < 3; a++) begin
      lo_edge[a] = COORD_MAX;
      hi_edge[a] = COORD_MIN;
    end
    peak_sq = 0;
  endfunction

  function automatic longint unsigned square_of(longint d);
    longint unsigned m;
    m = (d < 0) ? -d : d;
    return m * m;
  endfunction

  // Bit-by-bit floor root; roots here stay below 2^26
  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 27; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  // Fold one vertex into the running extents; on the closing vertex form the
  // result and reseed for the next model.
  task automatic fold_vertex(input vertex_t v, output bit closed, output extents_t r);
    longint          c [3];
    longint unsigned d2;
    longint unsigned diag2;
    c[0]  = $signed(v.vertex_x);
    c[1]  = $signed(v.vertex_y);
    c[2]  = $signed(v.vertex_z);
    d2    = 0;
    diag2 = 0;
    for (int a = 0; a < 3; a++) begin
      d2 += square_of(c[a]);
      if (c[a] < lo_edge[a]) lo_edge[a] = c[a];
      if (c[a] > hi_edge[a]) hi_edge[a] = c[a];
    end
    if (d2 > peak_sq) peak_sq = d2;
    closed = v.last_vertex;
    r      = '0;
    if (closed) begin
      for (int a = 0; a < 3; a++) diag2 += square_of(hi_edge[a] - lo_edge[a]);
      r.box_min_x       = COORD_BITS'(lo_edge[0]);
      r.box_min_y       = COORD_BITS'(lo_edge[1]);
      r.box_min_z       = COORD_BITS'(lo_edge[2]);
      r.box_max_x       = COORD_BITS'(hi_edge[0]);
      r.box_max_y       = COORD_BITS'(hi_edge[1]);
      r.box_max_z       = COORD_BITS'(hi_edge[2]);
      r.far_radius      = RADIUS_W'(floor_root(peak_sq));
      r.diagonal_length = DIAG_W'(floor_root(diag2));
      // arithmetic shift of the signed sum floors towards minus infinity
      r.centre_x        = COORD_BITS'((lo_edge[0] + hi_edge[0]) >>> 1);
      r.centre_y        = COORD_BITS'((lo_edge[1] + hi_edge[1]) >>> 1);
      r.centre_z        = COORD_BITS'((lo_edge[2] + hi_edge[2]) >>> 1);
      reseed_extents();
    end
  endtask

  // Mix of axis extremes, values near zero and the full range
  function automatic logic signed [COORD_BITS-1:0] pick_coord();
    unique case ($urandom_range(7))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2:       return COORD_BITS'($urandom_range(8191)) - COORD_BITS'(4096);
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  // Entered and left at a falling edge. Insert random gaps, then hold the word
  // until the block takes it, and queue the result it closes, if any.
  task automatic offer_vertex(input vertex_t v, input bit typed, input extents_t want);
    bit       closed;
    extents_t predicted;
    while ($urandom_range(99) < src_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fold_vertex(v, closed, predicted);
    if (closed) pending_extents.insert(pending_extents.size(), typed ? want : predicted);
    vertices_taken++;
    @(negedge clk);
  endtask

  task automatic send_model(input int len);
    for (int i = 0; i < len; i++) begin
      offer_vertex('{pick_coord(), pick_coord(), pick_coord(), 1'(i == len - 1)}, 1'b0, '0);
    end
  endtask

  // Drop valid and hold off until every queued result has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_extents.size() != 0);
  endtask

  task automatic note_field(input string name, input logic [31:0] want,
                            input logic [31:0] got);
    if (want !== got) begin
      if (mismatches < REPORT_LIMIT) begin
        $display("result %0d: %s expected %h, got %h", results_seen, name, want, got);
      end
      mismatches++;
    end
  endtask

  // Compare each result word taken from the block with the oldest expectation
  always @(posedge clk) begin
    extents_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_extents.size() == 0) begin
        if (mismatches < REPORT_LIMIT) begin
          $display("result %0d: unexpected word %h", results_seen, out_word);
        end
        mismatches++;
      end else begin
        want = pending_extents.pop_front();
        note_field("box_min_x", 32'(want.box_min_x), 32'(out_word.box_min_x));
        note_field("box_min_y", 32'(want.box_min_y), 32'(out_word.box_min_y));
        note_field("box_min_z", 32'(want.box_min_z), 32'(out_word.box_min_z));
        note_field("box_max_x", 32'(want.box_max_x), 32'(out_word.box_max_x));
        note_field("box_max_y", 32'(want.box_max_y), 32'(out_word.box_max_y));
        note_field("box_max_z", 32'(want.box_max_z), 32'(out_word.box_max_z));
        note_field("far_radius", 32'(want.far_radius), 32'(out_word.far_radius));
        note_field("diagonal_length", 32'(want.diagonal_length),
                   32'(out_word.diagonal_length));
        note_field("centre_x", 32'(want.centre_x), 32'(out_word.centre_x));
        note_field("centre_y", 32'(want.centre_y), 32'(out_word.centre_y));
        note_field("centre_z", 32'(want.centre_z), 32'(out_word.centre_z));
      end
      results_seen++;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("mesh_bounding_extents_tb: done, errors");
      $finish;
    end
  end

  // Sink: random stalls at the current rate, or a long hold-off on request
  // so that the output register fills and the block pushes back on its input.
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < sink_stall_pct);
      end
    end
  end

  initial begin
    int phase_start;
    int len;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_word        = '0;
    mismatches     = 0;
    results_seen   = 0;
    vertices_taken = 0;
    cycle_count    = 0;
    hold_request   = 1'b0;
    src_gap_pct    = 11;
    sink_stall_pct = 60;
    reseed_extents();

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed table first
    for (int i = 0; i < N_DIRECTED; i++) begin
      offer_vertex(directed_rows[i].vtx, directed_rows[i].typed, directed_rows[i].want);
    end

    // Random models in three idling phases: dense source with a busy sink,
    // the reverse, then both flat out with a long sink hold-off at the start.
    for (int phase = 0; phase < 3; phase++) begin
      unique case (phase)
        0:       begin src_gap_pct = 11; sink_stall_pct = 60; end
        1:       begin src_gap_pct = 60; sink_stall_pct = 11; end
        default: begin src_gap_pct = 0;  sink_stall_pct = 0;  end
      endcase
      if (phase == 2) hold_request = 1'b1;
      phase_start = vertices_taken;
      while (vertices_taken - phase_start < PHASE_ITEMS) begin
        // keep models short during the hold-off so results pile up behind it
        if (hold_request || hold_left > 0) begin
          len = $urandom_range(1, 2);
        end else if ($urandom_range(9) == 0) begin
          len = $urandom_range(9, 30);
        end else begin
          len = $urandom_range(1, 8);
        end
        send_model(len);
      end
      wait_drained();
    end

    // Let any stray word surface before judging
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("mesh_bounding_extents_tb: done, clean");
    end else begin
      $display("mesh_bounding_extents_tb: done, errors");
    end
    $finish;
  end

endmodule
